[hw/rtl/zbr_pkg.sv]
// ----------------------------------------------------------------------------
// zbr_pkg - shared constants and types
// Screen geometry, fixed-point widths, command codes and the request and
// response structs between the sequencer, the divider and the pixel memory.
// ----------------------------------------------------------------------------
package zbr_pkg;

    localparam int SCREEN_W = 200;
    localparam int SCREEN_H = 50;
    localparam int NPIX     = SCREEN_W * SCREEN_H;
    localparam int ADDR_W   = $clog2(NPIX);
    localparam int X_W      = $clog2(SCREEN_W);
    localparam int Y_W      = $clog2(SCREEN_H);

    // fixed-point widths
    localparam int DEN_W  = 35;   // |area term|
    localparam int NUM_W  = 53;   // offset numerator of a weight division
    localparam int Q_W    = 17;   // offset weight quotient
    localparam int WT_W   = 18;   // signed weight, covered range
    localparam int Z_W    = 24;   // depth
    localparam int CH_W   = 8;    // character
    localparam int CNT_W  = 14;   // written count
    localparam int WORD_W = Z_W + CH_W;

    localparam logic signed [Z_W-1:0] DEPTH_FAR  = 24'sh7FFFFF;
    localparam logic signed [Z_W-1:0] DEPTH_NEAR = -24'sh800000;
    localparam logic [CH_W-1:0]       CHAR_SPACE = 8'd32;
    localparam logic [CNT_W-1:0]      COUNT_MAX  = 14'h3FFF;
    localparam logic signed [WT_W-1:0] TOL_Q16   = -18'sd6;
    localparam logic signed [WT_W-1:0] ONE_Q16   = 18'sd65536;

    // commands
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_CHAR      = 1'd1;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num_v;
        logic [NUM_W-1:0] num_w;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] q_v;
        logic [Q_W-1:0] q_w;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

endpackage

[hw/rtl/zbr_mem.sv]
// ----------------------------------------------------------------------------
// zbr_mem - pixel store
// One word per pixel: depth in the upper bits, character in the low byte.
// Single port, registered read data held until the next read.
// ----------------------------------------------------------------------------
module zbr_mem
    import zbr_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [NPIX];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/zbr_div.sv]
// ----------------------------------------------------------------------------
// zbr_div - dual restoring divider
// Divides two non-negative numerators by one shared denominator, one quotient
// bit per cycle for both, giving a Q_W-bit quotient for each.
// ----------------------------------------------------------------------------
module zbr_div
    import zbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_BITS = $clog2(Q_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_W-1:0]    r_rem_v;
    logic [NUM_W-1:0]    r_rem_w;
    logic [NUM_W-1:0]    r_dsh;
    logic [Q_W-1:0]      r_q_v;
    logic [Q_W-1:0]      r_q_w;

    logic ge_v;
    logic ge_w;

    assign ge_v = r_rem_v >= r_dsh;
    assign ge_w = r_rem_w >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem_v <= i_req.num_v;
            r_rem_w <= i_req.num_w;
            r_dsh   <= NUM_W'(i_req.den) << (Q_W - 1);
            r_q_v   <= '0;
            r_q_w   <= '0;
        end else if (r_busy) begin
            if (ge_v) begin
                r_rem_v <= r_rem_v - r_dsh;
            end
            if (ge_w) begin
                r_rem_w <= r_rem_w - r_dsh;
            end
            r_q_v <= {r_q_v[Q_W-2:0], ge_v};
            r_q_w <= {r_q_w[Q_W-2:0], ge_w};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q_v  = r_q_v;
    assign o_rsp.q_w  = r_q_w;

endmodule

[hw/rtl/zbuffer_triangle_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// zbuffer_triangle_rasterizer_top - z-buffered triangle rasterizer
// Character screen and depth store in one pixel memory, walked by a
// sequencer with a shared weight divider.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives exactly one result word.
// Clear sweeps the whole pixel memory, one pixel per cycle. The same sweep
// runs after reset, with no result word; the slave side is not ready during
// it. Read looks up one pixel if its index is on the screen. Draw runs the
// triangle set-up and then, for each pixel of the clipped bounding box, a
// coarse weight range check; a pixel that passes waits on the divider, which
// yields one quotient bit per cycle for both weights, and then has its depth
// computed and compared unless the third weight falls below the tolerance.
// A degenerate triangle or empty box finishes after set-up with a count of
// zero. The result register lets the next command be taken while the last
// result word waits on the master side.
// ----------------------------------------------------------------------------
module zbuffer_triangle_rasterizer_top
    import zbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0: ax, ay, az, bx, by_coord, bz, cx, cy, cz, fill_char,
    // read_index, 2 zero bits
    input  logic [191:0]         s_axis_tdata,
    // tuser: func
    input  logic [1:0]           s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0: pixel_char, written_count, 2 zero bits
    output logic [23:0]          m_axis_tdata,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata
);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_RD2  = 4'd3;
    localparam logic [3:0] ST_T0   = 4'd4;
    localparam logic [3:0] ST_T1   = 4'd5;
    localparam logic [3:0] ST_T2   = 4'd6;
    localparam logic [3:0] ST_T3   = 4'd7;
    localparam logic [3:0] ST_P1   = 4'd8;
    localparam logic [3:0] ST_P2   = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_Z1   = 4'd11;
    localparam logic [3:0] ST_Z2   = 4'd12;
    localparam logic [3:0] ST_Z3   = 4'd13;
    localparam logic [3:0] ST_NEXT = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    localparam int CRD_W = 14;   // pixel coordinate before clipping
    localparam int LIM_W = 54;   // weight numerator and its limits

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_init;

    // configuration
    logic [15:0]     r_edge_thr;
    logic [CH_W-1:0] r_edge_char;

    // command word
    logic [1:0]              r_func;
    logic signed [15:0]      r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [Z_W-1:0]   r_az, r_bz, r_cz;
    logic [CH_W-1:0]         r_fill;
    logic [13:0]             r_ridx;

    // triangle set-up
    logic signed [16:0]      r_e0x, r_e0y, r_e1x, r_e1y;
    logic [X_W-1:0]          r_x0, r_x1, r_x;
    logic [Y_W-1:0]          r_y0, r_y1, r_y;
    logic                    r_empty;
    logic                    r_sgn;
    logic                    r_dzero;
    logic [DEN_W-1:0]        r_den;
    logic signed [LIM_W-1:0] r_lo, r_hi, r_six;
    logic [ADDR_W-1:0]       r_row;

    // pixel datapath
    logic signed [34:0]      r_m0, r_m1, r_m2, r_m3;
    logic signed [WT_W-1:0]  r_u, r_v, r_w;
    logic signed [41:0]      r_pu, r_pv, r_pw;
    logic [CNT_W-1:0]        r_count;
    logic [CH_W-1:0]         r_pc;

    // result register
    logic                    r_ovalid;
    logic [23:0]             r_odata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_mem_req          mem_req;
    logic [WORD_W-1:0] mem_rdata;
    logic [ADDR_W-1:0] r_caddr;

    logic accept;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // ---- bounding box, floor of min and ceiling of max, then clipped ----
    logic signed [15:0]      mnx, mxx, mny, mxy;
    logic signed [CRD_W-1:0] bx0, bx1, by0, by1;
    logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1;

    always_comb begin
        mnx = (r_ax < r_bx) ? r_ax : r_bx;
        mnx = (mnx < r_cx) ? mnx : r_cx;
        mxx = (r_ax > r_bx) ? r_ax : r_bx;
        mxx = (mxx > r_cx) ? mxx : r_cx;
        mny = (r_ay < r_by) ? r_ay : r_by;
        mny = (mny < r_cy) ? mny : r_cy;
        mxy = (r_ay > r_by) ? r_ay : r_by;
        mxy = (mxy > r_cy) ? mxy : r_cy;
        bx0 = CRD_W'(mnx >>> 4);
        by0 = CRD_W'(mny >>> 4);
        bx1 = CRD_W'((18'(mxx) + 18'sd15) >>> 4);
        by1 = CRD_W'((18'(mxy) + 18'sd15) >>> 4);
        cx0 = (bx0 < 0) ? '0 : bx0;
        cy0 = (by0 < 0) ? '0 : by0;
        cx1 = (bx1 > CRD_W'(SCREEN_W - 1)) ? CRD_W'(SCREEN_W - 1) : bx1;
        cy1 = (by1 > CRD_W'(SCREEN_H - 1)) ? CRD_W'(SCREEN_H - 1) : by1;
    end

    // ---- per-pixel numerators ----
    logic signed [17:0]      px, py;
    logic signed [35:0]      nv, nw;
    logic signed [LIM_W-1:0] big_v, big_w;
    logic                    in_rng;
    logic signed [35:0]      dsd;

    always_comb begin
        px    = 18'({1'b0, r_x, 4'b0000}) - 18'(r_ax);
        py    = 18'({1'b0, r_y, 4'b0000}) - 18'(r_ay);
        nv    = r_sgn ? (36'(r_m1) - 36'(r_m0)) : (36'(r_m0) - 36'(r_m1));
        nw    = r_sgn ? (36'(r_m3) - 36'(r_m2)) : (36'(r_m2) - 36'(r_m3));
        big_v = LIM_W'(nv) <<< 16;
        big_w = LIM_W'(nw) <<< 16;
        // weight in [-6, 65549) for both, else the pixel cannot be covered
        in_rng = (big_v >= r_lo) && (big_v < r_hi) &&
                 (big_w >= r_lo) && (big_w < r_hi);
        dsd   = 36'(r_m0) - 36'(r_m1);
    end

    // ---- depth ----
    logic signed [43:0]      zsum;
    logic signed [27:0]      zsh;
    logic signed [Z_W-1:0]   znew;
    logic signed [Z_W-1:0]   zold;
    logic                    nearer;
    logic                    edge_px;
    logic signed [WT_W-1:0]  thr;

    always_comb begin
        zsum = 44'(r_pu) + 44'(r_pv) + 44'(r_pw);
        zsh  = 28'(zsum >>> 16);
        if (zsh > 28'(DEPTH_FAR)) begin
            znew = DEPTH_FAR;
        end else if (zsh < 28'(DEPTH_NEAR)) begin
            znew = DEPTH_NEAR;
        end else begin
            znew = Z_W'(zsh);
        end
        zold    = mem_rdata[WORD_W-1:CH_W];
        nearer  = znew < zold;
        thr     = WT_W'({2'b00, r_edge_thr});
        edge_px = (r_u < thr) || (r_v < thr) || (r_w < thr);
    end

    logic [ADDR_W-1:0] pix_addr;
    logic              rd_ok;
    assign pix_addr = r_row + ADDR_W'(r_x);
    assign rd_ok    = 32'(r_ridx) < 32'(NPIX);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        FUNC_CLEAR: n_state = ST_CLR;
                        FUNC_DRAW:  n_state = ST_T0;
                        FUNC_READ:  n_state = ST_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLR: begin
                if (r_caddr == ADDR_W'(NPIX - 1)) begin
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_RD:   n_state = rd_ok ? ST_RD2 : ST_DONE;
            ST_RD2:  n_state = ST_DONE;
            ST_T0:   n_state = ST_T1;
            ST_T1:   n_state = ST_T2;
            ST_T2:   n_state = ST_T3;
            ST_T3:   n_state = (r_dzero || r_empty) ? ST_DONE : ST_P1;
            ST_P1:   n_state = ST_P2;
            ST_P2:   n_state = in_rng ? ST_DIV : ST_NEXT;
            ST_DIV:  n_state = div_rsp.done ? ST_Z1 : ST_DIV;
            ST_Z1: begin
                n_state = (ONE_Q16 - r_v - r_w < TOL_Q16) ? ST_NEXT : ST_Z2;
            end
            ST_Z2:   n_state = ST_Z3;
            ST_Z3:   n_state = ST_NEXT;
            ST_NEXT: begin
                if (r_x == r_x1 && r_y == r_y1) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_P1;
                end
            end
            ST_DONE: n_state = (!r_ovalid || m_axis_tready) ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_init      <= 1'b1;
            r_caddr     <= '0;
            r_ovalid    <= 1'b0;
            r_edge_thr  <= 16'd3277;
            r_edge_char <= 8'd35;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EDGE_THRESHOLD: r_edge_thr  <= i_cfg_wdata;
                    REG_EDGE_CHAR:      r_edge_char <= i_cfg_wdata[CH_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLR) begin
                r_caddr <= r_caddr + 1'b1;
                if (n_state != ST_CLR) begin
                    r_init <= 1'b0;
                end
            end else begin
                r_caddr <= '0;
            end
            if (r_state == ST_DONE && n_state == ST_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_count <= '0;
                r_pc    <= '0;
                if (accept) begin
                    r_func <= s_axis_tuser;
                    r_ax   <= s_axis_tdata[15:0];
                    r_ay   <= s_axis_tdata[31:16];
                    r_az   <= s_axis_tdata[55:32];
                    r_bx   <= s_axis_tdata[71:56];
                    r_by   <= s_axis_tdata[87:72];
                    r_bz   <= s_axis_tdata[111:88];
                    r_cx   <= s_axis_tdata[127:112];
                    r_cy   <= s_axis_tdata[143:128];
                    r_cz   <= s_axis_tdata[167:144];
                    r_fill <= s_axis_tdata[175:168];
                    r_ridx <= s_axis_tdata[189:176];
                end
            end
            ST_RD2: r_pc <= mem_rdata[CH_W-1:0];
            ST_T0: begin
                r_e0x   <= 17'(r_bx) - 17'(r_ax);
                r_e0y   <= 17'(r_by) - 17'(r_ay);
                r_e1x   <= 17'(r_cx) - 17'(r_ax);
                r_e1y   <= 17'(r_cy) - 17'(r_ay);
                r_x0    <= X_W'(cx0);
                r_x1    <= X_W'(cx1);
                r_y0    <= Y_W'(cy0);
                r_y1    <= Y_W'(cy1);
                r_empty <= (cx0 > cx1) || (cy0 > cy1);
            end
            ST_T1: begin
                r_m0 <= r_e0x * r_e1y;
                r_m1 <= r_e1x * r_e0y;
            end
            ST_T2: begin
                r_dzero <= (dsd == '0);
                r_sgn   <= dsd[35];
                r_den   <= dsd[35] ? DEN_W'(-dsd) : DEN_W'(dsd);
            end
            ST_T3: begin
                r_six <= (LIM_W'(r_den) << 2) + (LIM_W'(r_den) << 1);
                r_lo  <= -((LIM_W'(r_den) << 2) + (LIM_W'(r_den) << 1));
                // 65549 = 65536 + 8 + 4 + 1
                r_hi  <= (LIM_W'(r_den) << 16) + (LIM_W'(r_den) << 3) +
                         (LIM_W'(r_den) << 2) + LIM_W'(r_den);
                r_x   <= r_x0;
                r_y   <= r_y0;
                r_row <= ADDR_W'(32'(r_y0) * SCREEN_W);
            end
            ST_P1: begin
                r_m0 <= px * r_e1y;
                r_m1 <= r_e1x * py;
                r_m2 <= r_e0x * py;
                r_m3 <= px * r_e0y;
            end
            ST_DIV: begin
                r_v <= WT_W'(div_rsp.q_v) + TOL_Q16;
                r_w <= WT_W'(div_rsp.q_w) + TOL_Q16;
            end
            ST_Z1: r_u <= ONE_Q16 - r_v - r_w;
            ST_Z2: begin
                r_pu <= r_u * r_az;
                r_pv <= r_v * r_bz;
                r_pw <= r_w * r_cz;
            end
            ST_Z3: begin
                if (nearer && r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            ST_NEXT: begin
                if (r_x == r_x1) begin
                    r_x   <= r_x0;
                    r_y   <= r_y + 1'b1;
                    r_row <= r_row + ADDR_W'(SCREEN_W);
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            default: ;
        endcase
        if (r_state == ST_DONE && n_state == ST_IDLE) begin
            r_odata <= {2'b00, (r_func == FUNC_DRAW) ? r_count : CNT_W'(0),
                        (r_func == FUNC_READ) ? r_pc : CH_W'(0)};
        end
    end

    // ---- divider ----
    always_comb begin
        div_req.start = (r_state == ST_P2) && in_rng;
        div_req.den   = r_den;
        div_req.num_v = NUM_W'(big_v + r_six);
        div_req.num_w = NUM_W'(big_w + r_six);
    end

    zbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- pixel memory ----
    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = pix_addr;
        mem_req.wdata = {znew, (edge_px ? r_edge_char : r_fill)};
        case (r_state)
            ST_CLR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_caddr;
                mem_req.wdata = {DEPTH_FAR, CHAR_SPACE};
            end
            ST_RD: begin
                mem_req.re   = rd_ok;
                mem_req.addr = ADDR_W'(r_ridx);
            end
            ST_P2: mem_req.re = in_rng;
            ST_Z3: mem_req.we = nearer;
            default: ;
        endcase
    end

    zbr_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // ---- checks ----
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (32'(mem_req.addr) < 32'(NPIX)))
        else $error("pixel write beyond the screen");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the wait state");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result word raised without a finished command");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("pixel memory read and write in one cycle");

endmodule
